>>> src/sust_pkg.sv
// Package for the sorted unique set table: sizes, codes, state encoding and
// the result record passed from the sequencer to the output stage.
// Depends on nothing; every other file but sust_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package sust_pkg;

  // Number of entries the store can hold.
  localparam int unsigned CAPACITY = 64;

  localparam int unsigned ValW   = 32;
  localparam int unsigned ActW   = 2;
  localparam int unsigned PosW   = 6;
  localparam int unsigned StatW  = 3;
  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW   = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ERASED    = 3'd3,
    ST_BADPOS    = 3'd4,
    ST_READOK    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_ERASE,
    S_RDWAIT,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] read_value;
    logic [CntW-1:0]        count;
  } sust_res_t;

endpackage

`default_nettype wire

>>> src/sust_in_if.sv
// Input channel of the sorted unique set table: valid/ready and one request.
// Depends on sust_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sust_in_if
  import sust_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic [ActW-1:0]        action;
  logic signed [ValW-1:0] value;
  logic [PosW-1:0]        position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink (input valid, input action, input value, input position, output ready);

endinterface

`default_nettype wire

>>> src/sust_out_if.sv
// Output channel of the sorted unique set table: valid/ready and one result.
// Depends on sust_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sust_out_if
  import sust_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic signed [ValW-1:0] read_value;
  logic [CntW-1:0]        count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink (input valid, input status, input read_value, input count, output ready);

endinterface

`default_nettype wire

>>> src/sorted_unique_set_table.sv
// Top level of the sorted unique set table: sequencer plus output register.
// Depends on sust_pkg, sust_in_if, sust_out_if, sust_ram and sust_seq.
//
//   Channel  Dir  Handshake      Payload
//   in_i     in   valid / ready  action, value, position
//   out_o    out  valid / ready  status, read_value, count
//
// One request is worked on at a time; the entry RAM (one write and one
// registered read per cycle) sets the pace, one entry moved or compared
// per cycle. A read or erase at a position not below the count, and an
// unused action, end in a bad position status. An insert of a new value
// into a store that is not full moves the entries from its slot up by one
// and then writes the value; an erase moves the entries above the erased
// one down by one.
// Reset clears the count and the control state; the RAM is not cleared,
// since no slot at or past the count is ever read. A result waits in the
// output register while the next request is already taken and worked on;
// the sequencer only stalls if a second result is ready before the first
// has been transferred.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_set_table
  import sust_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sust_in_if.sink   in_i,
  sust_out_if.source out_o
);

  sust_res_t res;
  logic      res_valid;
  logic      res_ready;

  logic      ovalid_q;
  sust_res_t ores_q;

  sust_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // The output register can take a new result when it is empty or when its
  // current result is transferred in the same cycle.
  assign res_ready = !ovalid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      ores_q <= res;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.status     = ores_q.status;
  assign out_o.read_value = ores_q.read_value;
  assign out_o.count      = ores_q.count;

endmodule

`default_nettype wire

>>> src/sust_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Standalone, no package needed.
`timescale 1ns / 1ps
`default_nettype none

module sust_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/sust_seq.sv
// Sequencer of the sorted unique set table: scans, shifts and reads the
// entry RAM one entry per cycle and builds one result per request.
// Depends on sust_pkg, sust_in_if and sust_ram.
`timescale 1ns / 1ps
`default_nettype none

module sust_seq
  import sust_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sust_in_if.sink    in_i,
  output logic       res_valid_o,
  output sust_res_t  res_o,
  input  wire logic  res_ready_i
);

  state_e                 state_q, state_d;
  logic signed [ValW-1:0] val_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        slot_q, slot_d;
  logic [AddrW-1:0]       tag_q, tag_d;
  logic                   pend_q, pend_d;
  status_e                rstat_q, rstat_d;
  logic signed [ValW-1:0] rval_q, rval_d;

  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [ValW-1:0]        ram_wdata, ram_rdata;
  logic signed [ValW-1:0] rd_s;
  logic [CmpW-1:0]        pos_ext, cnt_ext;
  logic                   accept;

  sust_ram #(
    .Depth (CAPACITY),
    .Width (ValW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_s    = $signed(ram_rdata);
  assign pos_ext = CmpW'(in_i.position);
  assign cnt_ext = CmpW'(cnt_q);
  assign accept  = in_i.valid && in_i.ready;

  assign res_o.status     = rstat_q;
  assign res_o.read_value = rval_q;
  assign res_o.count      = cnt_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    tag_d       = tag_q;
    pend_d      = 1'b0;
    rstat_d     = rstat_q;
    rval_d      = rval_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          rval_d = '0;
          priority if (in_i.action == ACT_INSERT) begin
            idx_d   = '0;
            state_d = S_SCAN;
          end else if (in_i.action == ACT_ERASE && pos_ext < cnt_ext) begin
            idx_d   = CntW'(pos_ext + CmpW'(1));
            state_d = S_ERASE;
          end else if (in_i.action == ACT_READ && pos_ext < cnt_ext) begin
            ram_re    = 1'b1;
            ram_raddr = AddrW'(pos_ext);
            state_d   = S_RDWAIT;
          end else begin
            rstat_d = ST_BADPOS;
            state_d = S_RESP;
          end
        end
      end

      // Ascending scan for the first entry not below the new value.
      S_SCAN: begin
        if (pend_q && rd_s >= val_q) begin
          if (rd_s == val_q) begin
            rstat_d = ST_DUPLICATE;
            state_d = S_RESP;
          end else if (cnt_q == CntW'(CAPACITY)) begin
            rstat_d = ST_FULL;
            state_d = S_RESP;
          end else begin
            slot_d  = CntW'(tag_q);
            idx_d   = cnt_q;
            state_d = S_SHIFT;
          end
        end else if (!pend_q && idx_q == cnt_q) begin
          if (cnt_q == CntW'(CAPACITY)) begin
            rstat_d = ST_FULL;
            state_d = S_RESP;
          end else begin
            slot_d  = cnt_q;
            idx_d   = cnt_q;
            state_d = S_SHIFT;
          end
        end else if (idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(idx_q);
          tag_d     = AddrW'(idx_q);
          idx_d     = idx_q + CntW'(1);
          pend_d    = 1'b1;
        end
      end

      // Move entries slot..count-1 up by one, top first, then place the value.
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = tag_q + AddrW'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_q > slot_q) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(idx_q - CntW'(1));
          tag_d     = AddrW'(idx_q - CntW'(1));
          idx_d     = idx_q - CntW'(1);
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AddrW'(slot_q);
          ram_wdata = val_q;
          cnt_d     = cnt_q + CntW'(1);
          rstat_d   = ST_INSERTED;
          state_d   = S_RESP;
        end
      end

      // Move entries above the erased one down by one, bottom first.
      S_ERASE: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = tag_q - AddrW'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(idx_q);
          tag_d     = AddrW'(idx_q);
          idx_d     = idx_q + CntW'(1);
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          cnt_d   = cnt_q - CntW'(1);
          rstat_d = ST_ERASED;
          state_d = S_RESP;
        end
      end

      S_RDWAIT: begin
        rval_d  = rd_s;
        rstat_d = ST_READOK;
        state_d = S_RESP;
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= in_i.value;
    end
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    tag_q   <= tag_d;
    rstat_q <= rstat_d;
    rval_q  <= rval_d;
  end

endmodule

`default_nettype wire
